@@ src/tsdm_pkg.sv @@
// Shared types, constants and lookup functions for the tared scale display multiplexer.
package tsdm_pkg;

  localparam int DIGIT_COUNT = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam int READING_W = 24;
  localparam int NET_W     = 25;
  localparam int LIMIT_W   = 25;
  localparam int POS_W     = 3;
  localparam int HIST_W    = 16;
  localparam int SEG_W     = 8;
  localparam int RECIP_W   = 25;
  localparam int SHIFT_W   = 6;
  localparam int PROD_W    = READING_W + RECIP_W;
  localparam int QUOT10_W  = 21;

  localparam logic [HIST_W-1:0] HIST_FORCE = 16'hE000;
  localparam logic [HIST_W-1:0] HIST_TARE  = 16'hF000;

  localparam logic signed [LIMIT_W-1:0] LOW_LIMIT_RESET  = -25'sd9;
  localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RESET = 25'sd10010;

  localparam logic [RECIP_W-1:0] MOD10_RECIP = 25'd26843546;
  localparam int                 MOD10_SHIFT = 28;

  localparam logic [SEG_W-1:0] SEG_DP = 8'h01;

  typedef enum logic [0:0] {
    REG_LOW_LIMIT  = 1'b0,
    REG_HIGH_LIMIT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [READING_W-1:0] mag;
    logic [POS_W-1:0]     pos;
    logic                 err;
    logic                 tare;
  } entry_t;

  // ceil(2^s / 10^k) with s = 24 + ceil(log2(10^k)): exact quotient for 24-bit dividends
  function automatic logic [RECIP_W-1:0] div_recip(input logic [POS_W-1:0] pos);
    logic [RECIP_W-1:0] r;
    unique case (pos)
      3'd0:    r = 25'd27487791;
      3'd1:    r = 25'd17179870;
      3'd2:    r = 25'd21474837;
      3'd3:    r = 25'd26843546;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

  function automatic logic [SHIFT_W-1:0] div_shift(input logic [POS_W-1:0] pos);
    logic [SHIFT_W-1:0] s;
    unique case (pos)
      3'd0:    s = 6'd38;
      3'd1:    s = 6'd34;
      3'd2:    s = 6'd31;
      3'd3:    s = 6'd28;
      default: s = 6'd24;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'd0:    g = 8'h7E;
      4'd1:    g = 8'h0C;
      4'd2:    g = 8'hB6;
      4'd3:    g = 8'h9E;
      4'd4:    g = 8'hCC;
      4'd5:    g = 8'hDA;
      4'd6:    g = 8'hFA;
      4'd7:    g = 8'h4E;
      4'd8:    g = 8'hFE;
      4'd9:    g = 8'hDE;
      default: g = 8'h7E;
    endcase
    return g;
  endfunction

  function automatic logic [SEG_W-1:0] error_glyph(input logic [POS_W-1:0] pos);
    logic [SEG_W-1:0] g;
    unique case (pos)
      3'd0:    g = 8'hF2;
      3'd3:    g = 8'hB8;
      default: g = 8'hA0;
    endcase
    return g;
  endfunction

endpackage

@@ src/tared_scale_display_multiplexer.sv @@
// Top level of the tared scale display multiplexer.
// One reading enters per clock while in_stall is low and yields one segment byte for the
// next digit in the 0..4 scan; with no stall the sustained rate is one transaction per
// cycle. Each transaction passes the queue write, two reciprocal-multiply stages for the
// decimal digit and the output register. The front end computes net weight, limit check,
// debounce and tare in the accepting cycle; the queue keeps taking readings while the output
// side is stalled, and in_stall rises once it holds QUEUE_DEPTH transactions, with up
// to three more held in the digit pipeline. The user must write limits through the cfg
// port only while no transaction is in flight; the block itself does not enforce this.
module tared_scale_display_multiplexer #(
  parameter int QUEUE_DEPTH = tsdm_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_enable,
  input  logic [0:0]                            cfg_index,
  input  logic [tsdm_pkg::LIMIT_W-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tsdm_pkg::READING_W-1:0] weight_reading,
  input  logic                                  button_level,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tsdm_pkg::SEG_W-1:0]            segments,
  output logic [tsdm_pkg::POS_W-1:0]            digit_select,
  output logic                                  error_shown,
  output logic                                  tare_taken
);

  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  tsdm_pkg::entry_t push_entry;
  tsdm_pkg::entry_t pop_entry;

  assign in_stall = full;

  tsdm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .weight_reading   (weight_reading),
    .button_level     (button_level),
    .queue_full       (full),
    .push             (push),
    .push_entry       (push_entry)
  );

  tsdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  tsdm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segments     (segments),
    .digit_select (digit_select),
    .error_shown  (error_shown),
    .tare_taken   (tare_taken)
  );

endmodule

@@ src/tsdm_front.sv @@
// Front end: limit registers, tare and debounce state, net weight and classification.
module tsdm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_enable,
  input  logic [0:0]                           cfg_index,
  input  logic [tsdm_pkg::LIMIT_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  input  logic signed [tsdm_pkg::READING_W-1:0] weight_reading,
  input  logic                                 button_level,
  input  logic                                 queue_full,
  output logic                                 push,
  output tsdm_pkg::entry_t                     push_entry
);

  logic signed [tsdm_pkg::LIMIT_W-1:0]   low_limit;
  logic signed [tsdm_pkg::LIMIT_W-1:0]   high_limit;
  logic signed [tsdm_pkg::READING_W-1:0] tare_offset;
  logic [tsdm_pkg::HIST_W-1:0]           button_history;
  logic [tsdm_pkg::POS_W-1:0]            digit_position;

  logic [tsdm_pkg::HIST_W-1:0]           button_history_next;
  logic [tsdm_pkg::POS_W-1:0]            digit_position_next;
  logic [tsdm_pkg::POS_W-1:0]            pos;
  logic signed [tsdm_pkg::NET_W-1:0]     net;
  logic                                  tare;
  logic                                  err;

  assign push = in_valid && !queue_full;

  assign button_history_next = {button_history[tsdm_pkg::HIST_W-2:0], button_level}
                               | tsdm_pkg::HIST_FORCE;
  assign tare = (button_history_next == tsdm_pkg::HIST_TARE);

  assign net = tsdm_pkg::NET_W'(weight_reading) - tsdm_pkg::NET_W'(tare_offset);
  assign err = (net < low_limit) || (net > high_limit);

  assign pos = (digit_position >= tsdm_pkg::POS_W'(tsdm_pkg::DIGIT_COUNT)) ?
               '0 : digit_position;
  assign digit_position_next = (pos == tsdm_pkg::POS_W'(tsdm_pkg::DIGIT_COUNT - 1)) ?
                               '0 : pos + tsdm_pkg::POS_W'(1);

  always_comb begin
    push_entry.mag  = net[tsdm_pkg::NET_W-1] ? '0 : net[tsdm_pkg::READING_W-1:0];
    push_entry.pos  = pos;
    push_entry.err  = err;
    push_entry.tare = tare;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= tsdm_pkg::LOW_LIMIT_RESET;
      high_limit <= tsdm_pkg::HIGH_LIMIT_RESET;
    end else if (cfg_write_enable) begin
      unique case (tsdm_pkg::reg_index_t'(cfg_index))
        tsdm_pkg::REG_LOW_LIMIT:  low_limit  <= cfg_data;
        tsdm_pkg::REG_HIGH_LIMIT: high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tare_offset    <= '0;
      button_history <= '0;
      digit_position <= '0;
    end else if (push) begin
      button_history <= button_history_next;
      digit_position <= digit_position_next;
      if (tare) begin
        tare_offset <= weight_reading;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    digit_position < tsdm_pkg::POS_W'(tsdm_pkg::DIGIT_COUNT))
    else $error("digit position out of range");

  a_tare_latch: assert property (@(posedge clk) disable iff (rst)
    push && tare |=> tare_offset == $past(weight_reading))
    else $error("tare offset not latched");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    push && pos != tsdm_pkg::POS_W'(tsdm_pkg::DIGIT_COUNT - 1)
    |=> digit_position == $past(pos) + tsdm_pkg::POS_W'(1))
    else $error("digit position did not advance");

endmodule

@@ src/tsdm_queue.sv @@
// Short register-file queue between the front end and the digit pipeline.
module tsdm_queue #(
  parameter int DEPTH = tsdm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tsdm_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output tsdm_pkg::entry_t pop_entry,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsdm_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count mismatch");

endmodule

@@ src/tsdm_back.sv @@
// Back end: digit extraction by reciprocal multiply, glyph lookup and output register.
module tsdm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  tsdm_pkg::entry_t              pop_entry,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tsdm_pkg::SEG_W-1:0]    segments,
  output logic [tsdm_pkg::POS_W-1:0]    digit_select,
  output logic                          error_shown,
  output logic                          tare_taken
);

  // stage a: dividend times reciprocal of 10^k
  logic                              a_valid;
  logic [tsdm_pkg::PROD_W-1:0]       a_prod;
  logic [tsdm_pkg::POS_W-1:0]        a_pos;
  logic                              a_err;
  logic                              a_tare;

  // stage b: quotient and its reciprocal product for mod 10
  logic                              b_valid;
  logic [tsdm_pkg::READING_W-1:0]    b_quot;
  logic [tsdm_pkg::PROD_W-1:0]       b_prod;
  logic [tsdm_pkg::POS_W-1:0]        b_pos;
  logic                              b_err;
  logic                              b_tare;

  logic                              a_en;
  logic                              b_en;
  logic                              c_en;

  logic [tsdm_pkg::PROD_W-1:0]       a_shifted;
  logic [tsdm_pkg::READING_W-1:0]    quot;
  logic [tsdm_pkg::QUOT10_W-1:0]     quot10;
  logic [tsdm_pkg::READING_W-1:0]    quot10_x10;
  logic [tsdm_pkg::READING_W-1:0]    rem_full;
  logic [tsdm_pkg::SEG_W-1:0]        seg;

  assign c_en = !out_valid || !out_stall;
  assign b_en = !b_valid || c_en;
  assign a_en = !a_valid || b_en;
  assign pop  = !empty && a_en;

  assign a_shifted = a_prod >> tsdm_pkg::div_shift(a_pos);
  assign quot      = a_shifted[tsdm_pkg::READING_W-1:0];

  assign quot10     = b_prod[tsdm_pkg::MOD10_SHIFT +: tsdm_pkg::QUOT10_W];
  assign quot10_x10 = {quot10, 3'b000} + tsdm_pkg::READING_W'({quot10, 1'b0});
  assign rem_full   = b_quot - quot10_x10;

  always_comb begin
    if (b_err) begin
      seg = tsdm_pkg::error_glyph(b_pos);
    end else if (b_pos == tsdm_pkg::POS_W'(1)) begin
      seg = tsdm_pkg::digit_glyph(rem_full[3:0]) | tsdm_pkg::SEG_DP;
    end else begin
      seg = tsdm_pkg::digit_glyph(rem_full[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= pop;
      end
      if (b_en) begin
        b_valid <= a_valid;
      end
      if (c_en) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_prod <= pop_entry.mag * tsdm_pkg::div_recip(pop_entry.pos);
      a_pos  <= pop_entry.pos;
      a_err  <= pop_entry.err;
      a_tare <= pop_entry.tare;
    end
    if (b_en && a_valid) begin
      b_quot <= quot;
      b_prod <= quot * tsdm_pkg::MOD10_RECIP;
      b_pos  <= a_pos;
      b_err  <= a_err;
      b_tare <= a_tare;
    end
    if (c_en && b_valid) begin
      segments     <= seg;
      digit_select <= b_pos;
      error_shown  <= b_err;
      tare_taken   <= b_tare;
    end
  end

  a_error_no_dp: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_shown |-> (segments & tsdm_pkg::SEG_DP) == '0)
    else $error("decimal point lit in error pattern");

  a_dp_on_digit1: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error_shown && digit_select == tsdm_pkg::POS_W'(1)
    |-> (segments & tsdm_pkg::SEG_DP) != '0)
    else $error("decimal point missing on digit 1");

  a_digit_in_range: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_err |-> rem_full < tsdm_pkg::READING_W'(10))
    else $error("digit extraction out of range");

endmodule

@@ test/tsdm_display_check.sv @@
// Display checker: predicts each segment byte from the accepted readings and compares results.
module tsdm_display_check
  import tsdm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [0:0]                  cfg_index,
  input  logic [LIMIT_W-1:0]          cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [READING_W-1:0] weight_reading,
  input  logic                        button_level,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [SEG_W-1:0]            segments,
  input  logic [POS_W-1:0]            digit_select,
  input  logic                        error_shown,
  input  logic                        tare_taken,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SEG_W-1:0] seg;
    logic [POS_W-1:0] pos;
    logic             err;
    logic             tare;
  } digit_frame_t;

  localparam logic [SEG_W-1:0] NUMERAL_SEG [10] = '{
    8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC, 8'hDA, 8'hFA, 8'h4E, 8'hFE, 8'hDE
  };
  localparam logic [SEG_W-1:0] ERROR_SEG [DIGIT_COUNT] = '{
    8'hF2, 8'hA0, 8'hA0, 8'hB8, 8'hA0
  };

  logic signed [READING_W-1:0] tare_value;
  logic [HIST_W-1:0]           press_hist;
  logic [POS_W-1:0]            scan_pos;
  logic signed [LIMIT_W-1:0]   low_lim;
  logic signed [LIMIT_W-1:0]   high_lim;
  digit_frame_t                frames_due[$];

  function automatic digit_frame_t next_frame(input logic signed [READING_W-1:0] reading,
                                              input logic level);
    digit_frame_t f;
    longint net;
    longint mag;
    longint divisor;
    int k;
    net = longint'(reading) - longint'(tare_value);
    press_hist = (press_hist << 1) | HIST_W'(level) | HIST_FORCE;
    f.tare = (press_hist == HIST_TARE);
    if (f.tare) tare_value = reading;
    f.pos = scan_pos;
    f.err = (net < longint'(low_lim)) || (net > longint'(high_lim));
    if (f.err) begin
      f.seg = ERROR_SEG[scan_pos];
    end else begin
      mag = (net < 0) ? 0 : net;
      divisor = 1;
      for (k = scan_pos; k < DIGIT_COUNT - 1; k++) divisor *= 10;
      f.seg = NUMERAL_SEG[(mag / divisor) % 10];
      if (scan_pos == 1) f.seg |= SEG_DP;
    end
    scan_pos = (scan_pos == DIGIT_COUNT - 1) ? '0 : scan_pos + 1'b1;
    return f;
  endfunction

  task automatic check_field(input string field, input logic [SEG_W-1:0] want,
                             input logic [SEG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    digit_frame_t want;
    if (rst) begin
      tare_value = '0;
      press_hist = '0;
      scan_pos   = '0;
      low_lim    = LOW_LIMIT_RESET;
      high_lim   = HIGH_LIMIT_RESET;
      frames_due.delete();
    end else begin
      if (cfg_write_enable) begin
        if (cfg_index == REG_LOW_LIMIT) low_lim = cfg_data;
        else high_lim = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected transaction, segments %h digit %0d", $time, segments,
                   digit_select);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          check_field("segments", want.seg, segments);
          check_field("digit_select", SEG_W'(want.pos), SEG_W'(digit_select));
          check_field("error_shown", SEG_W'(want.err), SEG_W'(error_shown));
          check_field("tare_taken", SEG_W'(want.tare), SEG_W'(tare_taken));
        end
      end
      if (in_valid && !in_stall) frames_due.push_back(next_frame(weight_reading, button_level));
    end
    outstanding <= frames_due.size();
  end

endmodule

@@ test/tb_tared_scale_display_multiplexer.sv @@
// Testbench top: drives readings, button levels and limits into the display multiplexer.
module tb_tared_scale_display_multiplexer
  import tsdm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 215;
  localparam int PHASES          = 6;
  localparam int HOLD_CYCLES     = 60;
  localparam int FIRST_NETS [10] = '{0, 3, -1, -9, -10, 10010, 10011, 99999, 8388607, -8388608};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write_enable = 1'b0;
  logic [0:0]                  cfg_index = REG_LOW_LIMIT;
  logic [LIMIT_W-1:0]          cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [READING_W-1:0] weight_reading = '0;
  logic                        button_level = 1'b1;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [SEG_W-1:0]            segments;
  logic [POS_W-1:0]            digit_select;
  logic                        error_shown;
  logic                        tare_taken;
  int                          mismatches;
  int                          outstanding;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;
  int release_run = 0;
  int press_run   = 0;

  tared_scale_display_multiplexer DUT (.*);

  tsdm_display_check display_check (.*);

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [READING_W-1:0] pick_reading();
    logic [READING_W-1:0] r;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       r = 24'h7FFFFF;
          1:       r = 24'h800000;
          2:       r = 24'h000000;
          default: r = 24'hFFFFFF;
        endcase
      end
      1, 2:    r = READING_W'($urandom);
      3:       r = READING_W'(int'($urandom_range(0, 400000)) - 200000);
      default: r = READING_W'(int'($urandom_range(0, 12600)) - 100);
    endcase
    return r;
  endfunction

  // release stretch followed by a press, mostly long enough to tare, some noise
  function automatic logic next_level();
    if ($urandom_range(0, 19) == 0) return 1'($urandom_range(0, 1));
    if (release_run == 0 && press_run == 0) begin
      release_run = $urandom_range(1, 30);
      press_run = ($urandom_range(0, 9) < 6) ? $urandom_range(12, 20) : $urandom_range(1, 11);
    end
    if (release_run != 0) begin
      release_run--;
      return 1'b1;
    end
    press_run--;
    return 1'b0;
  endfunction

  task automatic send(input logic [READING_W-1:0] reading, input logic level);
    in_valid <= 1'b1;
    weight_reading <= reading;
    button_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limits(input logic [LIMIT_W-1:0] lo, input logic [LIMIT_W-1:0] hi);
    cfg_write_enable <= 1'b1;
    cfg_index <= REG_LOW_LIMIT;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_HIGH_LIMIT;
    cfg_data <= hi;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    int phase;
    int i;
    int n;
    int lo;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          1: write_limits(LIMIT_W'(-16777216), LIMIT_W'(16777215));
          2: write_limits(LIMIT_W'(16777215), LIMIT_W'(-16777216));
          3: begin
            lo = int'($urandom_range(0, 2500)) - 2000;
            write_limits(LIMIT_W'(lo), LIMIT_W'(lo + int'($urandom_range(0, 120000))));
          end
          4: write_limits(LIMIT_W'(-50), LIMIT_W'(200000));
          default: write_limits(LOW_LIMIT_RESET, HIGH_LIMIT_RESET);
        endcase
      end
      if (phase == 0) begin
        for (i = 0; i < 10; i++) send(READING_W'(FIRST_NETS[i]), 1'b1);
      end
      if (phase == 1) begin
        // big net in range, then tare at the negative extreme and read the positive one
        send(READING_W'(123456), 1'b1);
        for (i = 0; i < 12; i++) send(24'h800000, 1'b0);
        send(24'h7FFFFF, 1'b1);
        hold_req = 1'b1;
      end
      if (phase == PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 3 && i == ITEMS_PER_PHASE / 2) wait_idle();
        send(pick_reading(), next_level());
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 2000 && outstanding != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
